FILE: rtl/awf_pkg.sv
package awf_pkg;

    localparam int PIX_W   = 8;
    localparam int TVAL_W  = 5;
    localparam int WGT_W   = 16;
    localparam int ERR_W   = 40;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;
    localparam int SUM_W   = 25;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_CENTER = 3'd2,
        CFG_SIDE   = 3'd3,
        CFG_DIAG   = 3'd4
    } t_cfg_idx;

    // Queue entry between front and back
    typedef struct packed {
        logic                flush;
        logic [TVAL_W-1:0]   tval;
        logic [PIX_W-1:0]    orig;
    } t_entry;

    typedef struct packed {
        logic [WGT_W-1:0] w_center;
        logic [WGT_W-1:0] w_side;
        logic [WGT_W-1:0] w_diag;
    } t_weights;

    // Forward transform: largest a with a*a <= 4x+1
    function automatic logic [TVAL_W-1:0] anscombe(input logic [PIX_W-1:0] x);
        logic [PIX_W+1:0]  v;
        logic [TVAL_W-1:0] a;
        v = {x, 2'b01};
        a = '0;
        for (int k = 1; k < 32; k++) begin
            if (11'(k * k) <= {1'b0, v}) begin
                a = TVAL_W'(k);
            end
        end
        return a;
    endfunction

endpackage

FILE: rtl/awf_if.sv
interface awf_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel_in;
    logic [7:0] original_in;
    modport source (output valid, action, pixel_in, original_in, input ready);
    modport sink   (input valid, action, pixel_in, original_in, output ready);
endinterface

interface awf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_out;
    logic        frame_last;
    logic [39:0] error_sum;
    modport source (output valid, pixel_out, frame_last, error_sum, input ready);
    modport sink   (input valid, pixel_out, frame_last, error_sum, output ready);
endinterface

interface awf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/awf_front.sv
module awf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    awf_in_if.sink           i_pix,
    output logic             o_q_valid,
    output awf_pkg::t_entry  o_q_data,
    input  logic             i_q_pop
);

    awf_pkg::t_entry r_buf [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            push;
    awf_pkg::t_entry entry;

    assign i_pix.ready = (r_cnt != 2'd2);
    assign push        = i_pix.valid && i_pix.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_data    = r_buf[r_rd];

    // Classify and transform the incoming item
    always_comb begin
        entry.flush = i_pix.action;
        entry.tval  = awf_pkg::anscombe(i_pix.pixel_in);
        entry.orig  = i_pix.original_in;
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= entry;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: rtl/awf_back.sv
module awf_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]    i_height,
    input  awf_pkg::t_weights                  i_wgt,
    input  logic                               i_q_valid,
    input  awf_pkg::t_entry                    i_q_data,
    output logic                               o_q_pop,
    awf_out_if.source                          o_res
);

    localparam int RING = 2 * MAX_WIDTH + 3;
    localparam int AB   = $clog2(RING);
    localparam int PB   = $clog2(RING + 1);
    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int HB   = $clog2(MAX_HEIGHT + 1);
    localparam int M    = $clog2(MAX_HEIGHT);
    localparam int KB   = $clog2(M + 2);
    localparam int UB   = AB + M + 2;
    localparam int OB   = HB + WB + 6;
    localparam int RB   = HB + 2;
    localparam int CB   = WB + 2;
    localparam int IPB  = HB + WB + 1;
    localparam int MW   = awf_pkg::TVAL_W + awf_pkg::PIX_W;
    localparam logic signed [OB-1:0] RING_S = OB'(RING);

    typedef enum logic [3:0] {
        S_IDLE, S_PIXCHK, S_RDYMUL, S_RDYCMP, S_INIT, S_OFF, S_SLOT, S_MOD,
        S_READ, S_MAC, S_ORIGRD, S_ORIG, S_INV, S_ERR, S_SQ, S_OUT
    } t_state;

    t_state                    r_state;
    logic [MW-1:0]             r_mem [RING];
    logic [MW-1:0]             r_mem_q;
    logic [AB-1:0]             r_wp;
    logic [AB-1:0]             r_base;
    logic [AB-1:0]             r_slot;
    logic [PB-1:0]             r_pend;
    logic [WB-1:0]             r_icol;
    logic [HB-1:0]             r_irow;
    logic [WB-1:0]             r_ocol;
    logic [HB-1:0]             r_orow;
    logic [3:0]                r_tap;
    logic signed [OB-1:0]      r_offy;
    logic [IPB-1:0]            r_inpos;
    logic [UB-1:0]             r_u;
    logic [KB-1:0]             r_k;
    logic [awf_pkg::SUM_W-1:0] r_sum;
    logic [7:0]                r_csat;
    logic [7:0]                r_orig;
    logic [16:0]               r_t;
    logic [7:0]                r_y;
    logic [7:0]                r_d;
    logic [15:0]               r_sq;
    logic [awf_pkg::ERR_W-1:0] r_total;
    logic                      r_ovalid;
    logic [7:0]                r_opix;
    logic                      r_olast;
    logic [awf_pkg::ERR_W-1:0] r_oerr;

    logic signed [1:0]         dr;
    logic signed [1:0]         dc;
    logic signed [RB-1:0]      rr_raw, rr_c, hmax, dy;
    logic signed [CB-1:0]      cc_raw, cc_c, wmax, dx;
    logic signed [OB-1:0]      v;
    logic [UB-1:0]             step;
    logic [UB-1:0]             n_u;
    logic [awf_pkg::WGT_W-1:0] wt;
    logic [AB:0]               base_sum;
    logic [PB-1:0]             pend_m1;
    logic                      ready_ok;
    logic [16:0]               t_m3;
    logic [13:0]               y_wide;
    logic [7:0]                y_val;
    logic [awf_pkg::ERR_W:0]   tot_sum;
    logic [awf_pkg::ERR_W-1:0] tot_sat;
    logic                      ocol_wrap;
    logic                      orow_wrap;
    logic                      icol_wrap;
    logic                      irow_wrap;
    logic                      out_free;

    // Tap geometry from tap index
    always_comb begin
        unique case (r_tap)
            4'd0, 4'd1, 4'd2: dr = -2'sd1;
            4'd3, 4'd4, 4'd5: dr = 2'sd0;
            default:          dr = 2'sd1;
        endcase
        unique case (r_tap)
            4'd0, 4'd3, 4'd6: dc = -2'sd1;
            4'd1, 4'd4, 4'd7: dc = 2'sd0;
            default:          dc = 2'sd1;
        endcase
        unique case (r_tap)
            4'd4:                   wt = i_wgt.w_center;
            4'd1, 4'd3, 4'd5, 4'd7: wt = i_wgt.w_side;
            default:                wt = i_wgt.w_diag;
        endcase
    end

    // Replicate borders: clamp the tap position into the frame
    always_comb begin
        hmax   = $signed({2'b00, HB'(i_height - HB'(1))});
        wmax   = $signed({2'b00, WB'(i_width - WB'(1))});
        rr_raw = $signed({2'b00, r_orow}) + RB'(dr);
        cc_raw = $signed({2'b00, r_ocol}) + CB'(dc);
        if (rr_raw[RB-1]) begin
            rr_c = '0;
        end else if (rr_raw > hmax) begin
            rr_c = hmax;
        end else begin
            rr_c = rr_raw;
        end
        if (cc_raw[CB-1]) begin
            cc_c = '0;
        end else if (cc_raw > wmax) begin
            cc_c = wmax;
        end else begin
            cc_c = cc_raw;
        end
        dy = rr_c - $signed({2'b00, r_orow});
        dx = cc_c - $signed({2'b00, r_ocol});
    end

    // Ring address arithmetic
    always_comb begin
        v        = OB'($signed({1'b0, r_base})) + r_offy + OB'(dx);
        step     = UB'(RING) << r_k;
        n_u      = (r_u >= step) ? (r_u - step) : r_u;
        base_sum = (AB+1)'(r_wp) + (AB+1)'(RING) - (AB+1)'(r_pend);
        if (base_sum >= (AB+1)'(RING)) begin
            base_sum = base_sum - (AB+1)'(RING);
        end
        pend_m1  = r_pend - PB'(1);
        ready_ok = (r_pend != '0) &&
                   ((IPB'(r_pend) > r_inpos) ||
                    ((r_offy + OB'(dx)) <= $signed(OB'(pend_m1))));
    end

    // Inverse transform and error accumulation
    always_comb begin
        t_m3   = r_t - 17'd3;
        y_wide = t_m3[16:3];
        if (r_t < 17'd3) begin
            y_val = '0;
        end else if (y_wide > 14'd255) begin
            y_val = 8'd255;
        end else begin
            y_val = y_wide[7:0];
        end
        tot_sum = {1'b0, r_total} + (awf_pkg::ERR_W+1)'(r_sq);
        tot_sat = tot_sum[awf_pkg::ERR_W] ? '1 : tot_sum[awf_pkg::ERR_W-1:0];
        ocol_wrap = ({1'b0, r_ocol} + (WB+1)'(1)) >= {1'b0, i_width};
        orow_wrap = ({1'b0, r_orow} + (HB+1)'(1)) >= {1'b0, i_height};
        icol_wrap = ({1'b0, r_icol} + (WB+1)'(1)) >= {1'b0, i_width};
        irow_wrap = ({1'b0, r_irow} + (HB+1)'(1)) >= {1'b0, i_height};
        out_free  = !r_ovalid || o_res.ready;
    end

    assign o_q_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_res.valid      = r_ovalid;
    assign o_res.pixel_out  = r_opix;
    assign o_res.frame_last = r_olast;
    assign o_res.error_sum  = r_oerr;

    // Ring memory: write on pixel items, registered read
    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_data.flush) begin
            r_mem[r_wp] <= {i_q_data.tval, i_q_data.orig};
        end
        r_mem_q <= r_mem[r_slot];
    end

    // Sequencer: hold state, datapath registers and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_pend   <= '0;
            r_icol   <= '0;
            r_irow   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_tap    <= '0;
            r_slot   <= '0;
        end else begin
            if (o_res.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_data.flush) begin
                            r_tap   <= 4'd8;
                            r_state <= S_RDYMUL;
                        end else begin
                            r_wp    <= (r_wp == AB'(RING - 1)) ? '0 : r_wp + AB'(1);
                            r_pend  <= r_pend + PB'(1);
                            r_icol  <= icol_wrap ? '0 : r_icol + WB'(1);
                            if (icol_wrap) begin
                                r_irow <= irow_wrap ? '0 : r_irow + HB'(1);
                            end
                            r_state <= S_PIXCHK;
                        end
                    end
                end
                S_PIXCHK: begin
                    if ((PB+1)'(r_pend) >= (PB+1)'(i_width) + (PB+1)'(2)) begin
                        r_state <= S_INIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDYMUL: begin
                    r_inpos <= IPB'(IPB'(r_irow) * IPB'(i_width)) + IPB'(r_icol);
                    r_offy  <= OB'(dy) * OB'($signed({1'b0, i_width}));
                    r_state <= S_RDYCMP;
                end
                S_RDYCMP: begin
                    r_state <= ready_ok ? S_INIT : S_IDLE;
                end
                S_INIT: begin
                    r_base  <= AB'(base_sum);
                    r_tap   <= '0;
                    r_sum   <= '0;
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_offy  <= OB'(dy) * OB'($signed({1'b0, i_width}));
                    r_state <= S_SLOT;
                end
                S_SLOT: begin
                    // Near offsets wrap at most once; far ones go through the reduction
                    if (!v[OB-1] && v < RING_S) begin
                        r_slot  <= AB'(v);
                        r_state <= S_READ;
                    end else if (v[OB-1] && v >= -RING_S) begin
                        r_slot  <= AB'(v + RING_S);
                        r_state <= S_READ;
                    end else if (!v[OB-1] && v < (RING_S <<< 1)) begin
                        r_slot  <= AB'(v - RING_S);
                        r_state <= S_READ;
                    end else begin
                        r_u     <= UB'(v + (RING_S <<< M));
                        r_k     <= KB'(M + 1);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_u <= n_u;
                    r_k <= r_k - KB'(1);
                    if (r_k == '0) begin
                        r_slot  <= AB'(n_u);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_sum <= r_sum + awf_pkg::SUM_W'(r_mem_q[MW-1:awf_pkg::PIX_W]) *
                             awf_pkg::SUM_W'(wt);
                    if (r_tap == 4'd8) begin
                        r_slot  <= r_base;
                        r_state <= S_ORIGRD;
                    end else begin
                        r_tap   <= r_tap + 4'd1;
                        r_state <= S_OFF;
                    end
                end
                S_ORIGRD: begin
                    r_state <= S_ORIG;
                end
                S_ORIG: begin
                    r_orig  <= r_mem_q[awf_pkg::PIX_W-1:0];
                    r_csat  <= r_sum[awf_pkg::SUM_W-1] ? 8'd255 : r_sum[23:16];
                    r_state <= S_INV;
                end
                S_INV: begin
                    r_t     <= {16'(r_csat) * 16'(r_csat), 1'b0};
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_y     <= y_val;
                    r_d     <= (y_val > r_orig) ? y_val - r_orig : r_orig - y_val;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq    <= 16'(r_d) * 16'(r_d);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_opix   <= r_y;
                        r_olast  <= ocol_wrap && orow_wrap;
                        r_oerr   <= tot_sat;
                        r_total  <= (ocol_wrap && orow_wrap) ? '0 : tot_sat;
                        r_ocol   <= ocol_wrap ? '0 : r_ocol + WB'(1);
                        if (ocol_wrap) begin
                            r_orow <= orow_wrap ? '0 : r_orow + HB'(1);
                        end
                        r_pend   <= r_pend - PB'(1);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/anscombe_window_filter_top.sv
// Anscombe-domain 3x3 denoising filter. Noisy gray pixels enter in raster
// order with their clean originals (action 0); flush items (action 1) drain
// outputs still waiting at the end of a stream. Each pixel is mapped to
// isqrt(4x+1), filtered by a symmetric 3x3 Q0.16 kernel with replicated
// borders, mapped back and compared with its original; error_sum carries the
// saturating per-frame squared-error total and clears after frame_last.
// Outputs lag inputs by width+1 pixel items. A two-entry queue decouples
// the input from the engine, so up to two input transfers complete while
// a result waits. A pixel with no result only passes the entry check; one
// with a result is paced by serial reads of the ring's single read port:
// entry check, nine taps of offset, slot, read and multiply-accumulate,
// then original read, inverse transform, error update and output (which
// waits for a free result register). Flush items run a readiness check
// (multiply, then compare) instead of the entry check; taps with a ring
// offset far outside the window add a modular reduction. Configuration
// registers take effect immediately; write them only while the block is idle.
module anscombe_window_filter_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    awf_in_if.sink    i_pix,
    awf_out_if.source o_res,
    awf_cfg_if.sink   i_cfg
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    logic [8:0]               r_img_w;
    logic [8:0]               r_img_h;
    awf_pkg::t_weights        r_wgt;
    logic [WB-1:0]            eff_w;
    logic [HB-1:0]            eff_h;
    logic                     q_valid;
    logic                     q_pop;
    awf_pkg::t_entry          q_data;

    assign i_cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w        <= 9'd256;
            r_img_h        <= 9'd256;
            r_wgt.w_center <= 16'd7282;
            r_wgt.w_side   <= 16'd7282;
            r_wgt.w_diag   <= 16'd7282;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                awf_pkg::CFG_WIDTH:  r_img_w        <= i_cfg.data[8:0];
                awf_pkg::CFG_HEIGHT: r_img_h        <= i_cfg.data[8:0];
                awf_pkg::CFG_CENTER: r_wgt.w_center <= i_cfg.data;
                awf_pkg::CFG_SIDE:   r_wgt.w_side   <= i_cfg.data;
                awf_pkg::CFG_DIAG:   r_wgt.w_diag   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb begin
        if (r_img_w < 9'd2) begin
            eff_w = WB'(2);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            eff_w = WB'(MAX_WIDTH);
        end else begin
            eff_w = WB'(r_img_w);
        end
        if (r_img_h < 9'd2) begin
            eff_h = HB'(2);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            eff_h = HB'(MAX_HEIGHT);
        end else begin
            eff_h = HB'(r_img_h);
        end
    end

    awf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    awf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .i_wgt     (r_wgt),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
